/* rtl/argtok_pkg.sv */
// Shared types and constants of the argument tokenizer.
`default_nettype none
package argtok_pkg;

   localparam int CHAR_W      = 8;
   localparam int MAXTOK_W    = 7;
   localparam int OFFSET_W    = 12;
   localparam int COUNT_W     = 7;
   localparam int CSR_INDEX_W = 2;
   localparam int FIFO_DEPTH  = 2;
   localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

   localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'd9;
   localparam logic [CHAR_W-1:0] CHAR_NL      = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_CR      = 8'd13;
   localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'd32;
   localparam logic [CHAR_W-1:0] CHAR_DQUOTE  = 8'd34;
   localparam logic [CHAR_W-1:0] CHAR_SQUOTE  = 8'd39;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_TOKENS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMMENT    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIMITER  = 2'd2;

   localparam logic [MAXTOK_W-1:0] MAX_TOKENS_RESET = 7'd64;

   typedef enum logic [1:0] {
      MODE_SKIP   = 2'd0,
      MODE_WORD   = 2'd1,
      MODE_QUOTED = 2'd2,
      MODE_DONE   = 2'd3
   } mode_type;

   typedef struct packed {
      logic restart;
      logic is_zero;
      logic is_gap;
      logic is_stop;
      logic is_space;
      logic is_sep;
      logic is_squote;
      logic is_dquote;
   } char_class_type;

   typedef struct packed {
      logic                token_starts;
      logic [OFFSET_W-1:0] start_offset;
      logic                terminator_here;
      logic                parse_done;
      logic [COUNT_W-1:0]  token_count;
   } result_type;

endpackage
`default_nettype wire

/* rtl/argtok_front.sv */
// Front stage: accepts characters and registers their classification.
`default_nettype none
module argtok_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [argtok_pkg::CHAR_W-1:0]     req_char,
   input  wire logic                              req_restart,
   input  wire logic [argtok_pkg::CHAR_W-1:0]     comment_char,
   input  wire logic [argtok_pkg::CHAR_W-1:0]     delimiter_char,
   output logic                                   push_valid,
   input  wire logic                              push_ready,
   output argtok_pkg::char_class_type             push_class
);

   logic                       valid_ff, valid_in;
   argtok_pkg::char_class_type class_ff, class_in;
   logic                       is_comment, is_delim, is_space;

   always_comb begin
      is_comment = (req_char != '0) && (req_char == comment_char);
      is_delim   = (req_char != '0) && (req_char == delimiter_char);
      is_space   = (req_char == argtok_pkg::CHAR_SPACE) ||
                   ((req_char >= argtok_pkg::CHAR_TAB) && (req_char <= argtok_pkg::CHAR_CR));
      class_in.restart   = req_restart;
      class_in.is_zero   = (req_char == '0);
      class_in.is_gap    = (req_char == argtok_pkg::CHAR_SPACE) ||
                           (req_char == argtok_pkg::CHAR_TAB) || is_delim;
      class_in.is_stop   = is_comment || (req_char == argtok_pkg::CHAR_NL);
      class_in.is_space  = is_space;
      class_in.is_sep    = is_space || is_delim;
      class_in.is_squote = (req_char == argtok_pkg::CHAR_SQUOTE);
      class_in.is_dquote = (req_char == argtok_pkg::CHAR_DQUOTE);
   end

   assign req_tready = !valid_ff || push_ready;
   assign push_valid = valid_ff;
   assign push_class = class_ff;

   always_comb begin
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         class_ff <= class_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/argtok_fifo.sv */
// Short queue of classified characters between front and back.
`default_nettype none
module argtok_fifo (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push_valid,
   output logic                       push_ready,
   input  wire argtok_pkg::char_class_type push_class,
   output logic                       pop_valid,
   input  wire logic                  pop_ready,
   output argtok_pkg::char_class_type pop_class
);

   argtok_pkg::char_class_type            entry_ff [argtok_pkg::FIFO_DEPTH];
   logic [argtok_pkg::FIFO_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [argtok_pkg::FIFO_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [argtok_pkg::FIFO_CNT_W-1:0]     count_ff, count_in;
   logic                                  do_push, do_pop;

   assign push_ready = (count_ff != argtok_pkg::FIFO_CNT_W'(argtok_pkg::FIFO_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_class  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == argtok_pkg::FIFO_PTR_W'(argtok_pkg::FIFO_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == argtok_pkg::FIFO_PTR_W'(argtok_pkg::FIFO_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_class;
      end
   end

endmodule
`default_nettype wire

/* rtl/argtok_back.sv */
// Back stage: parse state machine and registered result.
`default_nettype none
module argtok_back #(
   parameter int MAX_TOKENS   = 64,
   parameter int BUFFER_BYTES = 4096
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 pop_valid,
   output logic                                      pop_ready,
   input  wire argtok_pkg::char_class_type           pop_class,
   input  wire logic [argtok_pkg::MAXTOK_W-1:0]      max_tokens,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output argtok_pkg::result_type                    rsp_result
);

   localparam int CW = $clog2(MAX_TOKENS + 1);
   localparam int OW = $clog2(BUFFER_BYTES);
   localparam int LW = (CW > argtok_pkg::MAXTOK_W) ? CW : argtok_pkg::MAXTOK_W;
   localparam logic [LW-1:0] TokCap  = LW'(MAX_TOKENS);
   localparam logic [OW-1:0] LastOff = OW'(BUFFER_BYTES - 1);

   argtok_pkg::mode_type   mode_ff, mode_in, cur_mode;
   logic                   qdbl_ff, qdbl_in, cur_qdbl;
   logic [CW-1:0]          cnt_ff, cnt_in, cur_cnt, cnt_inc;
   logic [OW-1:0]          off_ff, off_in, cur_off, off_next;
   logic [LW-1:0]          lim, max_w;
   logic                   at_limit, inc_at_limit;
   logic                   starts, term, do_pop;
   logic [OW-1:0]          start_off;
   logic [31:0]            start_wide, cnt_wide;
   logic                   rsp_valid_ff, rsp_valid_in;
   argtok_pkg::result_type result_ff, result_in;

   assign max_w        = LW'(max_tokens);
   assign lim          = (max_w > TokCap) ? TokCap : max_w;
   assign cur_mode     = pop_class.restart ? argtok_pkg::MODE_SKIP : mode_ff;
   assign cur_qdbl     = pop_class.restart ? 1'b0 : qdbl_ff;
   assign cur_cnt      = pop_class.restart ? '0 : cnt_ff;
   assign cur_off      = pop_class.restart ? '0 : off_ff;
   assign cnt_inc      = cur_cnt + 1'b1;
   assign at_limit     = (LW'(cur_cnt) >= lim);
   assign inc_at_limit = (LW'(cnt_inc) >= lim);
   assign off_next     = (cur_off == LastOff) ? '0 : cur_off + 1'b1;

   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      mode_in   = cur_mode;
      qdbl_in   = cur_qdbl;
      cnt_in    = cur_cnt;
      off_in    = off_next;
      starts    = 1'b0;
      term      = 1'b0;
      start_off = '0;
      unique case (cur_mode)
         argtok_pkg::MODE_SKIP: begin
            priority if (at_limit) begin
               mode_in = argtok_pkg::MODE_DONE;
            end else if (pop_class.is_gap) begin
               mode_in = argtok_pkg::MODE_SKIP;
            end else if (pop_class.is_zero || pop_class.is_stop) begin
               mode_in = argtok_pkg::MODE_DONE;
            end else if (pop_class.is_squote || pop_class.is_dquote) begin
               qdbl_in   = pop_class.is_dquote;
               cnt_in    = cnt_inc;
               starts    = 1'b1;
               start_off = off_next;
               mode_in   = argtok_pkg::MODE_QUOTED;
            end else begin
               cnt_in    = cnt_inc;
               starts    = 1'b1;
               start_off = cur_off;
               if (pop_class.is_space) begin
                  term    = 1'b1;
                  mode_in = inc_at_limit ? argtok_pkg::MODE_DONE : argtok_pkg::MODE_SKIP;
               end else begin
                  mode_in = argtok_pkg::MODE_WORD;
               end
            end
         end
         argtok_pkg::MODE_WORD: begin
            priority if (pop_class.is_zero) begin
               mode_in = argtok_pkg::MODE_DONE;
            end else if (pop_class.is_stop) begin
               term    = 1'b1;
               mode_in = argtok_pkg::MODE_DONE;
            end else if (pop_class.is_sep) begin
               term    = 1'b1;
               mode_in = at_limit ? argtok_pkg::MODE_DONE : argtok_pkg::MODE_SKIP;
            end else begin
               mode_in = argtok_pkg::MODE_WORD;
            end
         end
         argtok_pkg::MODE_QUOTED: begin
            priority if (pop_class.is_zero) begin
               mode_in = argtok_pkg::MODE_DONE;
            end else if ((cur_qdbl && pop_class.is_dquote) ||
                         (!cur_qdbl && pop_class.is_squote)) begin
               term    = 1'b1;
               mode_in = at_limit ? argtok_pkg::MODE_DONE : argtok_pkg::MODE_SKIP;
            end else begin
               mode_in = argtok_pkg::MODE_QUOTED;
            end
         end
         argtok_pkg::MODE_DONE: begin
            mode_in = argtok_pkg::MODE_DONE;
         end
         default: begin
            mode_in = argtok_pkg::MODE_DONE;
         end
      endcase

      start_wide                = 32'(start_off);
      cnt_wide                  = 32'(cnt_in);
      result_in.token_starts    = starts;
      result_in.start_offset    = start_wide[argtok_pkg::OFFSET_W-1:0];
      result_in.terminator_here = term;
      result_in.parse_done      = (mode_in == argtok_pkg::MODE_DONE);
      result_in.token_count     = cnt_wide[argtok_pkg::COUNT_W-1:0];

      if (do_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= argtok_pkg::MODE_SKIP;
         qdbl_ff      <= 1'b0;
         cnt_ff       <= '0;
         off_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (do_pop) begin
            mode_ff <= mode_in;
            qdbl_ff <= qdbl_in;
            cnt_ff  <= cnt_in;
            off_ff  <= off_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_pop) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = result_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      LW'(cnt_ff) <= TokCap)
      else $error("token count above its cap");
   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !pop_class.restart && (mode_ff == argtok_pkg::MODE_DONE))
      |=> (mode_ff == argtok_pkg::MODE_DONE))
      else $error("parse left done without restart");
   a_start_counts: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && result_ff.token_starts) |-> (result_ff.token_count != '0))
      else $error("token start reported with zero count");
   a_start_grows: assert property (@(posedge clock) disable iff (reset)
      (do_pop && starts) |=> (cnt_ff != '0))
      else $error("token start did not advance the count");
`endif

endmodule
`default_nettype wire

/* rtl/argument_tokenizer_top.sv */
// Top level of the argument tokenizer: configuration registers and stage wiring.
`default_nettype none
// Splits a line buffer, streamed one byte per transaction, into whitespace,
// delimiter or quote bounded tokens and returns one result per byte. The block
// takes one byte every cycle while no stall holds its input; a byte's result is
// registered in turn by the front classification register, the two-entry
// queue and the back result register, and the parse-state update in the back
// stage, made once for each byte, sets that rate.
// Stalls on the result side fill the queue before the input side is held.
// Configuration writes are taken every cycle; that they apply only to bytes
// accepted after the block has drained is for the user to keep; the block does not enforce it.
module argument_tokenizer_top #(
   parameter int MAX_TOKENS   = 64,
   parameter int BUFFER_BYTES = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] character
   input  wire logic [0:0]  req_tuser,   // [0] restart
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [0] token_starts, [12:1] start_offset,
                                         // [13] terminator_here, [14] parse_done,
                                         // [21:15] token_count, [23:22] zero
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_data
);

   logic [argtok_pkg::MAXTOK_W-1:0] max_tokens_ff;
   logic [argtok_pkg::CHAR_W-1:0]   comment_ff, delimiter_ff;
   logic                            push_valid, push_ready, pop_valid, pop_ready;
   argtok_pkg::char_class_type      push_class, pop_class;
   argtok_pkg::result_type          result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_tokens_ff <= argtok_pkg::MAX_TOKENS_RESET;
         comment_ff    <= '0;
         delimiter_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            argtok_pkg::CSR_MAX_TOKENS: max_tokens_ff <= csr_data[argtok_pkg::MAXTOK_W-1:0];
            argtok_pkg::CSR_COMMENT:    comment_ff    <= csr_data;
            argtok_pkg::CSR_DELIMITER:  delimiter_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   argtok_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_char       (req_tdata),
      .req_restart    (req_tuser[0]),
      .comment_char   (comment_ff),
      .delimiter_char (delimiter_ff),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_class     (push_class)
   );

   argtok_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_class (push_class),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_class  (pop_class)
   );

   argtok_back #(
      .MAX_TOKENS   (MAX_TOKENS),
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_class  (pop_class),
      .max_tokens (max_tokens_ff),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (result)
   );

   assign rsp_tdata = {2'b00, result.token_count, result.parse_done,
                       result.terminator_here, result.start_offset, result.token_starts};

endmodule
`default_nettype wire

/* sim/argument_tokenizer_top_tb.sv */
// Self-checking testbench of the argument tokenizer: stream stimulus and per-byte result check.
module argument_tokenizer_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TOKEN_CAP      = 64;
   localparam int BUFFER_BYTES   = 4096;
   localparam int RANDOM_ITEMS   = 700;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_PRINTS     = 40;

   localparam logic [argtok_pkg::CHAR_W-1:0] CHAR_NUL   = 8'd0;
   localparam logic [argtok_pkg::CHAR_W-1:0] CHAR_VT    = 8'd11;
   localparam logic [argtok_pkg::CHAR_W-1:0] CHAR_FF    = 8'd12;
   localparam logic [argtok_pkg::CHAR_W-1:0] CHAR_HASH  = "#";
   localparam logic [argtok_pkg::CHAR_W-1:0] CHAR_COMMA = ",";
   localparam logic [argtok_pkg::CHAR_W-1:0] CHAR_HIGH  = 8'hFF;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;

   logic [argtok_pkg::MAXTOK_W-1:0] cfg_max_tokens;
   logic [argtok_pkg::CHAR_W-1:0]   cfg_comment;
   logic [argtok_pkg::CHAR_W-1:0]   cfg_delim;

   argtok_pkg::mode_type            scan_state;
   logic                            in_dquote;
   logic [argtok_pkg::COUNT_W-1:0]  tokens_seen;
   logic [argtok_pkg::OFFSET_W-1:0] byte_pos;

   argtok_pkg::result_type token_results_due[$];
   argtok_pkg::result_type want;
   int         mismatch_count = 0;
   int         results_seen = 0;
   int         bytes_sent = 0;
   int         stall_left = 0;
   int         idle_cycles = 0;
   bit         gaps_on = 1'b1;
   bit         stalls_on = 1'b1;
   bit         fresh_line = 1'b1;

   argument_tokenizer_top #(
      .MAX_TOKENS   (TOKEN_CAP),
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [argtok_pkg::OFFSET_W-1:0] next_pos(
      input logic [argtok_pkg::OFFSET_W-1:0] pos);
      return (pos == argtok_pkg::OFFSET_W'(BUFFER_BYTES - 1)) ? '0 : pos + 1'b1;
   endfunction

   function automatic bit is_ctype_space(input logic [argtok_pkg::CHAR_W-1:0] ch);
      return (ch == argtok_pkg::CHAR_SPACE) ||
             (ch >= argtok_pkg::CHAR_TAB && ch <= argtok_pkg::CHAR_CR);
   endfunction

   function automatic argtok_pkg::result_type scan_byte(
      input logic [argtok_pkg::CHAR_W-1:0] ch, input logic line_begin);
      argtok_pkg::result_type res;
      int         limit;
      bit         comment_hit;
      bit         delim_hit;
      res = '0;
      if (line_begin) begin
         scan_state  = argtok_pkg::MODE_SKIP;
         in_dquote   = 1'b0;
         tokens_seen = '0;
         byte_pos    = '0;
      end
      limit       = (cfg_max_tokens > TOKEN_CAP) ? TOKEN_CAP : int'(cfg_max_tokens);
      comment_hit = (ch != CHAR_NUL) && (ch == cfg_comment);
      delim_hit   = (ch != CHAR_NUL) && (ch == cfg_delim);
      case (scan_state)
         argtok_pkg::MODE_SKIP: begin
            if (tokens_seen >= limit) begin
               scan_state = argtok_pkg::MODE_DONE;
            end else if (ch == argtok_pkg::CHAR_SPACE || ch == argtok_pkg::CHAR_TAB ||
                         delim_hit) begin
               scan_state = argtok_pkg::MODE_SKIP;
            end else if (ch == CHAR_NUL || comment_hit || ch == argtok_pkg::CHAR_NL) begin
               scan_state = argtok_pkg::MODE_DONE;
            end else if (ch == argtok_pkg::CHAR_SQUOTE || ch == argtok_pkg::CHAR_DQUOTE) begin
               in_dquote          = (ch == argtok_pkg::CHAR_DQUOTE);
               tokens_seen        = tokens_seen + 1'b1;
               res.token_starts   = 1'b1;
               res.start_offset   = next_pos(byte_pos);
               scan_state         = argtok_pkg::MODE_QUOTED;
            end else begin
               tokens_seen        = tokens_seen + 1'b1;
               res.token_starts   = 1'b1;
               res.start_offset   = byte_pos;
               if (is_ctype_space(ch)) begin
                  res.terminator_here = 1'b1;
                  scan_state = (tokens_seen >= limit) ? argtok_pkg::MODE_DONE :
                                                        argtok_pkg::MODE_SKIP;
               end else begin
                  scan_state = argtok_pkg::MODE_WORD;
               end
            end
         end
         argtok_pkg::MODE_WORD: begin
            if (ch == CHAR_NUL) begin
               scan_state = argtok_pkg::MODE_DONE;
            end else if (comment_hit || ch == argtok_pkg::CHAR_NL) begin
               res.terminator_here = 1'b1;
               scan_state = argtok_pkg::MODE_DONE;
            end else if (is_ctype_space(ch) || delim_hit) begin
               res.terminator_here = 1'b1;
               scan_state = (tokens_seen >= limit) ? argtok_pkg::MODE_DONE :
                                                     argtok_pkg::MODE_SKIP;
            end
         end
         argtok_pkg::MODE_QUOTED: begin
            if (ch == CHAR_NUL) begin
               scan_state = argtok_pkg::MODE_DONE;
            end else if (ch == (in_dquote ? argtok_pkg::CHAR_DQUOTE :
                                            argtok_pkg::CHAR_SQUOTE)) begin
               res.terminator_here = 1'b1;
               scan_state = (tokens_seen >= limit) ? argtok_pkg::MODE_DONE :
                                                     argtok_pkg::MODE_SKIP;
            end
         end
         default: begin
         end
      endcase
      res.parse_done  = (scan_state == argtok_pkg::MODE_DONE);
      res.token_count = tokens_seen;
      byte_pos = next_pos(byte_pos);
      return res;
   endfunction

   function automatic int pick_len(input bit enabled);
      int r;
      if (!enabled) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTS) $display("mismatch: %s", msg);
   endtask

   task automatic check_field(input string name, input int unsigned got,
                              input int unsigned exp_val);
      if (got != exp_val)
         report_mismatch($sformatf("result %0d %s got %0d want %0d",
                                   results_seen, name, got, exp_val));
   endtask

   always @(negedge clock) begin
      if (stall_left == 0) stall_left = pick_len(stalls_on);
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (token_results_due.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with no byte pending", results_seen));
         end else begin
            want = token_results_due.pop_front();
            check_field("token_starts", rsp_tdata[0], want.token_starts);
            check_field("start_offset", rsp_tdata[12:1], want.start_offset);
            check_field("terminator_here", rsp_tdata[13], want.terminator_here);
            check_field("parse_done", rsp_tdata[14], want.parse_done);
            check_field("token_count", rsp_tdata[21:15], want.token_count);
            check_field("padding", rsp_tdata[23:22], 0);
         end
         results_seen++;
      end
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   task automatic send_byte(input logic [argtok_pkg::CHAR_W-1:0] ch, input logic line_begin);
      int gap;
      gap = pick_len(gaps_on);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tuser  <= line_begin;
      do @(posedge clock); while (!req_tready);
      token_results_due.push_back(scan_byte(ch, line_begin));
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic emit(input logic [argtok_pkg::CHAR_W-1:0] ch);
      send_byte(ch, fresh_line);
      fresh_line = 1'b0;
   endtask

   task automatic emit_text(input string s);
      foreach (s[i]) emit(s[i]);
   endtask

   task automatic settle(input int extra);
      req_tvalid <= 1'b0;
      while (token_results_due.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [argtok_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         argtok_pkg::CSR_MAX_TOKENS: cfg_max_tokens = value[argtok_pkg::MAXTOK_W-1:0];
         argtok_pkg::CSR_COMMENT:    cfg_comment = value;
         argtok_pkg::CSR_DELIMITER:  cfg_delim = value;
         default: begin
         end
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(input logic [argtok_pkg::MAXTOK_W-1:0] lim,
                            input logic [7:0] comment, input logic [7:0] delim);
      settle(DRAIN_CYCLES);
      write_csr(argtok_pkg::CSR_MAX_TOKENS, {1'b0, lim});
      write_csr(argtok_pkg::CSR_COMMENT, comment);
      write_csr(argtok_pkg::CSR_DELIMITER, delim);
   endtask

   function automatic logic [argtok_pkg::CHAR_W-1:0] word_byte(input bit opening);
      logic [argtok_pkg::CHAR_W-1:0] c;
      do begin
         c = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(33, 126)) :
                                          8'($urandom_range(1, 255));
      end while (is_ctype_space(c) || c == cfg_delim || c == cfg_comment ||
                 (opening && (c == argtok_pkg::CHAR_SQUOTE || c == argtok_pkg::CHAR_DQUOTE)));
      return c;
   endfunction

   function automatic logic [argtok_pkg::CHAR_W-1:0] blank_byte();
      case ($urandom_range(0, 2))
         0: return argtok_pkg::CHAR_SPACE;
         1: return argtok_pkg::CHAR_TAB;
         default: return (cfg_delim != CHAR_NUL) ? cfg_delim : argtok_pkg::CHAR_SPACE;
      endcase
   endfunction

   task automatic send_random_line();
      int                            ntok;
      int                            len;
      int                            r;
      logic [argtok_pkg::CHAR_W-1:0] q;
      logic [argtok_pkg::CHAR_W-1:0] c;
      fresh_line = 1'b1;
      if ($urandom_range(0, 99) < 15) begin
         fresh_line = $urandom_range(0, 1);
         len = $urandom_range(1, 20);
         repeat (len) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
         return;
      end
      repeat ($urandom_range(0, 2)) emit(blank_byte());
      ntok = $urandom_range(0, 6);
      for (int k = 0; k < ntok; k++) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            emit(word_byte(1'b1));
            repeat ($urandom_range(0, 5)) emit(word_byte(1'b0));
         end else if (r < 85) begin
            q = $urandom_range(0, 1) ? argtok_pkg::CHAR_DQUOTE : argtok_pkg::CHAR_SQUOTE;
            emit(q);
            repeat ($urandom_range(0, 5)) begin
               do c = 8'($urandom_range(1, 255)); while (c == q);
               emit(c);
            end
            if ($urandom_range(0, 9) != 0) emit(q);
         end else begin
            emit(8'($urandom_range(CHAR_VT, argtok_pkg::CHAR_CR)));
         end
         if ($urandom_range(0, 9) == 0) emit(8'($urandom_range(CHAR_VT, argtok_pkg::CHAR_CR)));
         repeat ($urandom_range(1, 3)) emit(blank_byte());
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
         emit(CHAR_NUL);
      end else if (r < 75) begin
         emit(argtok_pkg::CHAR_NL);
      end else if (r < 90 && cfg_comment != CHAR_NUL) begin
         emit(cfg_comment);
         repeat ($urandom_range(0, 3)) emit(word_byte(1'b0));
      end
      if ($urandom_range(0, 9) < 3) repeat ($urandom_range(1, 3)) emit(8'($urandom_range(0, 255)));
   endtask

   task automatic test_plain_tokens();
      fresh_line = 1'b1;
      emit_text("ab");
      emit(argtok_pkg::CHAR_TAB);
      emit_text("'x y' \"q\"");
      emit(CHAR_VT);
      emit(argtok_pkg::CHAR_CR);
      emit(CHAR_HIGH);
      emit(argtok_pkg::CHAR_NL);
      emit_text("z");
      fresh_line = 1'b1;
      emit(argtok_pkg::CHAR_SQUOTE);
      emit(CHAR_NUL);
   endtask

   task automatic test_comment_and_delimiter();
      configure(7'd64, CHAR_HASH, CHAR_COMMA);
      fresh_line = 1'b1;
      emit_text(",a,b#c");
      fresh_line = 1'b1;
      emit_text("d");
      emit(CHAR_NUL);
   endtask

   task automatic test_token_limit();
      configure(7'd0, CHAR_HASH, CHAR_COMMA);
      fresh_line = 1'b1;
      emit_text("a");
      configure(7'd1, CHAR_NUL, CHAR_NUL);
      fresh_line = 1'b1;
      emit_text("a b");
      configure(7'd2, CHAR_NUL, CHAR_NUL);
      fresh_line = 1'b1;
      emit_text("x 'y' z");
   endtask

   task automatic test_random_lines();
      int                              first_byte;
      int                              phase_end;
      logic [argtok_pkg::MAXTOK_W-1:0] lim;
      logic [7:0]                      cm;
      logic [7:0]                      dl;
      first_byte = bytes_sent;
      while (bytes_sent - first_byte < RANDOM_ITEMS) begin
         case ($urandom_range(0, 5))
            0: lim = 7'd0;
            1: lim = 7'd1;
            2: lim = 7'($urandom_range(2, 8));
            3: lim = 7'd64;
            4: lim = 7'd127;
            default: lim = 7'($urandom_range(0, 127));
         endcase
         case ($urandom_range(0, 3))
            0: cm = CHAR_NUL;
            1: cm = CHAR_HASH;
            2: cm = CHAR_HIGH;
            default: cm = 8'($urandom_range(1, 255));
         endcase
         case ($urandom_range(0, 3))
            0: dl = CHAR_NUL;
            1: dl = CHAR_COMMA;
            2: dl = 8'h80;
            default: dl = 8'($urandom_range(1, 255));
         endcase
         configure(lim, cm, dl);
         gaps_on   = ($urandom_range(0, 3) != 0);
         stalls_on = ($urandom_range(0, 3) != 0);
         phase_end = bytes_sent + $urandom_range(60, 120);
         while (bytes_sent < phase_end) begin
            send_random_line();
            if ($urandom_range(0, 39) == 0) settle(0);
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      cfg_max_tokens = argtok_pkg::MAX_TOKENS_RESET;
      cfg_comment    = CHAR_NUL;
      cfg_delim      = CHAR_NUL;
      void'(scan_byte(CHAR_NUL, 1'b1));
      @(negedge clock);
      test_plain_tokens();
      test_comment_and_delimiter();
      test_token_limit();
      test_random_lines();
      settle(DRAIN_CYCLES);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
